FILE: hw/rtl/zlib_stored_block_decoder_unit_defines.svh
// Assertion macros shared by the RTL of the zlib stored-block decoder.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ZLIB_STORED_BLOCK_DECODER_UNIT_DEFINES_SVH
`define ZLIB_STORED_BLOCK_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset
`define ZSBD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent in a cycle implies consequent in the same cycle
`define ZSBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ZSBD_ASSERT_ALWAYS(lbl, cond, msg)
`define ZSBD_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/zsbd_pkg.sv
// Package for the zlib stored-block decoder: parse phases, status codes,
// Adler-32 constants and the header check function. No dependencies.
package zsbd_pkg;

  typedef enum logic [3:0] {
    PH_HDR0  = 4'd0,
    PH_HDR1  = 4'd1,
    PH_BLOCK = 4'd2,
    PH_LEN0  = 4'd3,
    PH_LEN1  = 4'd4,
    PH_NLEN0 = 4'd5,
    PH_NLEN1 = 4'd6,
    PH_DATA  = 4'd7,
    PH_TRAIL = 4'd8,
    PH_DRAIN = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HDR   = 3'd1,
    ST_BAD_BLOCK = 3'd2,
    ST_LEN_MISM  = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_TRAILING  = 3'd5,
    ST_CHECKSUM  = 3'd6
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    status_t    status;
  } result_t;

  localparam logic [15:0] ADLER_MOD   = 16'd65521;
  localparam logic [3:0]  CM_DEFLATE  = 4'h8;
  localparam logic [3:0]  CINFO_MAX   = 4'h7;

  // True when a 16-bit value is a multiple of 31 (2^5 = 1 mod 31: fold 5-bit digits)
  function automatic logic mod31_is_zero(input logic [15:0] v);
    logic [6:0] s1;
    logic [5:0] s2;
    s1 = {2'b0, v[4:0]} + {2'b0, v[9:5]} + {2'b0, v[14:10]} + {6'b0, v[15]};
    s2 = {1'b0, s1[4:0]} + {4'b0, s1[6:5]};
    return (s2 == 6'd0) || (s2 == 6'd31);
  endfunction

endpackage

FILE: hw/rtl/zlib_stored_block_decoder_unit.sv
// Top level of the zlib stored-block decoder: header, block and trailer parse,
// payload pass-through and running Adler-32. Depends on zsbd_pkg and the defines header.
//
//  channel  | dir | tdata                        | side band
//  s_axis   | in  | [7:0] in_byte                | tlast = is_last
//  m_axis   | out | [7:0] out_byte, [10:8] status | tuser = kind
//
// One byte per cycle while the skid register is empty: each accepted byte is parsed
// and its result registered in the same cycle; the two 17-bit modular adds of the
// Adler-32 update set the path. A skid register behind the output register keeps the
// input open for one more item while the output is stalled.
// rst is synchronous and active high; it returns the parser to the first header byte.
`include "zlib_stored_block_decoder_unit_defines.svh"

module zlib_stored_block_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        m_axis_tuser    // kind
);
  import zsbd_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  first_header_byte, first_header_byte_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        final_seen, final_seen_next;
  logic [15:0] sum_low, sum_low_next;
  logic [15:0] sum_high, sum_high_next;
  logic [1:0]  trailer_count, trailer_count_next;
  logic        trailer_mismatch, trailer_mismatch_next;

  // Output register and skid stage
  result_t out_res, skid_res, new_res;
  logic    out_valid, skid_valid;
  logic    res_fire;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic [15:0] inv_len;
  logic [16:0] lo_add, hi_add;
  logic [15:0] lo_mod;
  logic [7:0]  trail_ref;
  logic        give_status, give_payload, end_check;
  logic        drain_ph;
  status_t     code;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign last          = s_axis_tlast;
  assign inv_len       = ~bytes_left;

  // Adler-32 update for one payload byte
  always_comb begin
    lo_add = {1'b0, sum_low} + {9'b0, b};
    lo_mod = (lo_add >= {1'b0, ADLER_MOD}) ? lo_add[15:0] - ADLER_MOD : lo_add[15:0];
    hi_add = {1'b0, sum_high} + {1'b0, lo_mod};
  end

  // Pick the expected trailer byte, most significant first
  always_comb begin
    unique case (trailer_count)
      2'd0:    trail_ref = sum_high[15:8];
      2'd1:    trail_ref = sum_high[7:0];
      2'd2:    trail_ref = sum_low[15:8];
      default: trail_ref = sum_low[7:0];
    endcase
  end

  // Next state and result of one item
  always_comb begin
    phase_next             = phase;
    first_header_byte_next = first_header_byte;
    bytes_left_next        = bytes_left;
    final_seen_next        = final_seen;
    sum_low_next           = sum_low;
    sum_high_next          = sum_high;
    trailer_count_next     = trailer_count;
    trailer_mismatch_next  = trailer_mismatch;
    give_status            = 1'b0;
    give_payload           = 1'b0;
    end_check              = 1'b1;
    drain_ph               = 1'b0;
    code                   = ST_OK;

    unique case (phase)
      PH_HDR0: begin
        if (b[3:0] != CM_DEFLATE || b[7:4] > CINFO_MAX) begin
          give_status = 1'b1;
          code        = ST_BAD_HDR;
        end else begin
          first_header_byte_next = b;
          phase_next             = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (!mod31_is_zero({first_header_byte, b}) || b[5]) begin
          give_status = 1'b1;
          code        = ST_BAD_HDR;
        end else begin
          phase_next = PH_BLOCK;
        end
      end
      PH_BLOCK: begin
        if (b[7:1] != 7'd0) begin
          give_status = 1'b1;
          code        = ST_BAD_BLOCK;
        end else begin
          final_seen_next = b[0];
          phase_next      = PH_LEN0;
        end
      end
      PH_LEN0: begin
        bytes_left_next = {8'd0, b};
        phase_next      = PH_LEN1;
      end
      PH_LEN1: begin
        bytes_left_next = {b, bytes_left[7:0]};
        phase_next      = PH_NLEN0;
      end
      PH_NLEN0: begin
        if (b != inv_len[7:0]) begin
          give_status = 1'b1;
          code        = ST_LEN_MISM;
        end else begin
          phase_next = PH_NLEN1;
        end
      end
      PH_NLEN1: begin
        if (b != inv_len[15:8]) begin
          give_status = 1'b1;
          code        = ST_LEN_MISM;
        end else if (bytes_left == 16'd0) begin
          phase_next = final_seen ? PH_TRAIL : PH_BLOCK;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        end_check = 1'b0;
        if (last) begin
          give_status = 1'b1;
          code        = ST_TRUNC;
        end else begin
          give_payload    = 1'b1;
          sum_low_next    = lo_mod;
          sum_high_next   = (hi_add >= {1'b0, ADLER_MOD}) ?
                            hi_add[15:0] - ADLER_MOD : hi_add[15:0];
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            phase_next = final_seen ? PH_TRAIL : PH_BLOCK;
          end
        end
      end
      PH_TRAIL: begin
        trailer_mismatch_next = trailer_mismatch || (trail_ref != b);
        if (trailer_count == 2'd3) begin
          end_check   = 1'b0;
          give_status = 1'b1;
          if (!last) begin
            code = ST_TRAILING;
          end else begin
            code = trailer_mismatch_next ? ST_CHECKSUM : ST_OK;
          end
        end else begin
          trailer_count_next = trailer_count + 2'd1;
        end
      end
      default: begin
        // Drain: drop bytes until the last one
        end_check = 1'b0;
        drain_ph  = 1'b1;
      end
    endcase

    // Stream ended before the trailer was complete
    if (end_check && !give_status && last) begin
      give_status = 1'b1;
      code        = ST_TRUNC;
    end

    if (give_status && !last) begin
      phase_next = PH_DRAIN;
    end

    // Last byte after a status, or while draining: back to reset state
    if (last && (give_status || drain_ph)) begin
      phase_next             = PH_HDR0;
      first_header_byte_next = 8'd0;
      bytes_left_next        = 16'd0;
      final_seen_next        = 1'b0;
      sum_low_next           = 16'd1;
      sum_high_next          = 16'd0;
      trailer_count_next     = 2'd0;
      trailer_mismatch_next  = 1'b0;
    end

    new_res.kind     = give_status ? KIND_STATUS : KIND_PAYLOAD;
    new_res.out_byte = give_status ? 8'd0 : b;
    new_res.status   = give_status ? code : ST_OK;
  end

  assign res_fire = accept && (give_status || give_payload);

  // Parser state registers: advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      first_header_byte <= 8'd0;
      bytes_left        <= 16'd0;
      final_seen        <= 1'b0;
      sum_low           <= 16'd1;
      sum_high          <= 16'd0;
      trailer_count     <= 2'd0;
      trailer_mismatch  <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      first_header_byte <= first_header_byte_next;
      bytes_left        <= bytes_left_next;
      final_seen        <= final_seen_next;
      sum_low           <= sum_low_next;
      sum_high          <= sum_high_next;
      trailer_count     <= trailer_count_next;
      trailer_mismatch  <= trailer_mismatch_next;
    end
  end

  // Output register with skid stage: hold on stall, refill from skid first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_axis_tready) begin
      if (res_fire) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_axis_tready) begin
      if (res_fire) begin
        skid_res <= new_res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (res_fire) begin
      out_res <= new_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.status, out_res.out_byte};
  assign m_axis_tuser  = out_res.kind;

  `ZSBD_ASSERT_IMPLY(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `ZSBD_ASSERT_ALWAYS(a_sum_low_range, sum_low < ADLER_MOD, "sum_low out of range")
  `ZSBD_ASSERT_ALWAYS(a_sum_high_range, sum_high < ADLER_MOD, "sum_high out of range")
  `ZSBD_ASSERT_IMPLY(a_data_len, phase == PH_DATA, bytes_left != 16'd0, "payload at zero count")

endmodule

FILE: tb/zsbd_stream_checker.sv
// Scoreboard for the zlib stored-block decoder: predicts payload and status items
// from accepted input bytes and compares them with the output channel.
// Depends on zsbd_pkg for the phase, status, kind and result types.
`timescale 1ns / 100ps

module zsbd_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // is_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  input  logic        m_axis_tuser,   // kind
  output int          fail_count,
  output int          pending,
  output int          parsed_count
);
  import zsbd_pkg::*;

  // Parser state mirrored from the block
  phase_t      parse_ph;
  logic [7:0]  hdr_first;
  logic [15:0] blk_len;
  logic        last_blk;
  logic [15:0] adler_lo;
  logic [15:0] adler_hi;
  logic [1:0]  trl_idx;
  logic        trl_bad;

  result_t decoded_q[$];
  result_t want;
  result_t made;
  bit      emits;
  int      mism_count = 0;
  int      waiting = 0;
  int      parsed_n = 0;

  assign fail_count   = mism_count;
  assign pending      = waiting;
  assign parsed_count = parsed_n;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mism_count++;
  endtask

  task automatic restart_parse();
    parse_ph  = PH_HDR0;
    hdr_first = 8'h00;
    blk_len   = 16'h0000;
    last_blk  = 1'b0;
    adler_lo  = 16'd1;
    adler_hi  = 16'd0;
    trl_idx   = 2'd0;
    trl_bad   = 1'b0;
  endtask

  // Advance the parser by one byte and give the item it causes, if any
  task automatic decode_byte(input logic [7:0] b, input logic last,
                             output bit has_item, output result_t item);
    logic [15:0] inv;
    logic [16:0] acc;
    logic [31:0] adler;
    logic        fault;
    bit          drop;
    status_t     code;
    inv      = ~blk_len;
    acc      = '0;
    adler    = {adler_hi, adler_lo};
    fault    = 1'b0;
    drop     = 1'b0;
    code     = ST_OK;
    has_item = 1'b0;
    item     = '{kind: KIND_PAYLOAD, out_byte: 8'h00, status: ST_OK};
    case (parse_ph)
      PH_HDR0: begin
        if (b[3:0] != 4'h8 || b[7:4] > 4'h7) begin
          fault = 1'b1;
          code  = ST_BAD_HDR;
        end else begin
          hdr_first = b;
          parse_ph  = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (({hdr_first, b} % 16'd31) != 16'd0 || b[5]) begin
          fault = 1'b1;
          code  = ST_BAD_HDR;
        end else begin
          parse_ph = PH_BLOCK;
        end
      end
      PH_BLOCK: begin
        if (b[7:1] != 7'd0) begin
          fault = 1'b1;
          code  = ST_BAD_BLOCK;
        end else begin
          last_blk = b[0];
          parse_ph = PH_LEN0;
        end
      end
      PH_LEN0: begin
        blk_len  = {8'h00, b};
        parse_ph = PH_LEN1;
      end
      PH_LEN1: begin
        blk_len[15:8] = b;
        parse_ph      = PH_NLEN0;
      end
      PH_NLEN0: begin
        if (b != inv[7:0]) begin
          fault = 1'b1;
          code  = ST_LEN_MISM;
        end else begin
          parse_ph = PH_NLEN1;
        end
      end
      PH_NLEN1: begin
        if (b != inv[15:8]) begin
          fault = 1'b1;
          code  = ST_LEN_MISM;
        end else if (blk_len == 16'd0) begin
          parse_ph = last_blk ? PH_TRAIL : PH_BLOCK;
        end else begin
          parse_ph = PH_DATA;
        end
      end
      PH_DATA: begin
        if (last) begin
          fault = 1'b1;
          code  = ST_TRUNC;
        end else begin
          // Fold the byte into both Adler-32 sums modulo 65521
          acc = {1'b0, adler_lo} + {9'd0, b};
          if (acc >= 17'd65521) acc = acc - 17'd65521;
          adler_lo = acc[15:0];
          acc = {1'b0, adler_hi} + {1'b0, adler_lo};
          if (acc >= 17'd65521) acc = acc - 17'd65521;
          adler_hi = acc[15:0];
          blk_len  = blk_len - 16'd1;
          if (blk_len == 16'd0) parse_ph = last_blk ? PH_TRAIL : PH_BLOCK;
          has_item      = 1'b1;
          item.out_byte = b;
        end
      end
      PH_TRAIL: begin
        if (adler[8 * (3 - trl_idx) +: 8] != b) trl_bad = 1'b1;
        if (trl_idx == 2'd3) begin
          fault = 1'b1;
          if (!last) code = ST_TRAILING;
          else code = trl_bad ? ST_CHECKSUM : ST_OK;
        end else begin
          trl_idx = trl_idx + 2'd1;
        end
      end
      default: begin
        // Swallow bytes until the end of the stream
        drop = 1'b1;
        if (last) restart_parse();
      end
    endcase
    // A stream that ends before its trailer is truncated
    if (!drop && !fault && !has_item && last) begin
      fault = 1'b1;
      code  = ST_TRUNC;
    end
    if (fault) begin
      has_item = 1'b1;
      item     = '{kind: KIND_STATUS, out_byte: 8'h00, status: code};
      if (last) restart_parse();
      else parse_ph = PH_DRAIN;
    end
  endtask

  // Compare output items first: a result never leaves in the cycle of its byte
  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      decoded_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("item with none expected, tuser=%0b tdata=%h",
                                    m_axis_tuser, m_axis_tdata));
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("kind %0b, expected %0b", m_axis_tuser, want.kind));
          if (m_axis_tdata[7:0] !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      m_axis_tdata[7:0], want.out_byte));
          if (m_axis_tdata[10:8] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_axis_tdata[10:8], want.status));
          if (m_axis_tdata[15:11] !== 5'd0)
            report_mismatch($sformatf("pad bits %b not zero", m_axis_tdata[15:11]));
        end
      end
      // Count every accepted input item
      if (s_axis_tvalid && s_axis_tready) begin
        parsed_n++;
        decode_byte(s_axis_tdata, s_axis_tlast, emits, made);
        if (emits) decoded_q.push_back(made);
      end
    end
    waiting = decoded_q.size();
  end

endmodule

FILE: tb/tb_zlib_stored_block_decoder_unit.sv
// Top of the zlib stored-block decoder testbench: clock, reset, stream
// generation with idle and stall patterns, watchdog and verdict.
// Depends on the decoder RTL, zsbd_pkg and zsbd_stream_checker.
`timescale 1ns / 100ps

module tb_zlib_stored_block_decoder_unit;
  import zsbd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count;
  int pending;
  int parsed_count;

  int src_idle_pct = 17;
  int snk_idle_pct = 85;
  int hold_seq = 0;
  int stuck;
  int pick;

  logic [7:0] strm[$];

  zlib_stored_block_decoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  zsbd_stream_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .parsed_count (parsed_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one byte, with random idle cycles ahead of it, and hold until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic play_stream();
    foreach (strm[i]) send_byte(strm[i], i == strm.size() - 1);
  endtask

  // Build a well-formed zlib stream of stored blocks with its Adler-32 trailer
  function automatic void make_stream(input int nblk, input bit big);
    int          a;
    int          s;
    int          len;
    logic [7:0]  cmf;
    logic [7:0]  flg;
    logic [7:0]  d;
    logic [15:0] w;
    strm.delete();
    cmf = {4'($urandom_range(7)), 4'h8};
    flg = {2'($urandom_range(3)), 6'b0};
    flg[4:0] = 5'((31 - ({cmf, flg} % 16'd31)) % 31);
    strm.push_back(cmf);
    strm.push_back(flg);
    a = 1;
    s = 0;
    for (int k = 0; k < nblk; k++) begin
      if (big) len = 270;
      else if ($urandom_range(9) == 0) len = 0;
      else if ($urandom_range(9) < 7) len = $urandom_range(8, 1);
      else len = $urandom_range(40, 9);
      w = 16'(len);
      strm.push_back({7'd0, k == nblk - 1});
      strm.push_back(w[7:0]);
      strm.push_back(w[15:8]);
      strm.push_back(~w[7:0]);
      strm.push_back(~w[15:8]);
      for (int j = 0; j < len; j++) begin
        // Bytes near 0xFF push the low sum past its modulus
        d = big ? 8'($urandom_range(255, 240)) : 8'($urandom_range(255));
        strm.push_back(d);
        a = (a + d) % 65521;
        s = (s + a) % 65521;
      end
    end
    w = 16'(s);
    strm.push_back(w[15:8]);
    strm.push_back(w[7:0]);
    w = 16'(a);
    strm.push_back(w[15:8]);
    strm.push_back(w[7:0]);
  endfunction

  // Break one part of the stream; sometimes end the stream on the broken byte
  function automatic void corrupt_stream();
    int at;
    int n;
    at = -1;
    case ($urandom_range(15))
      0: begin
        strm[0][7:4] = 4'($urandom_range(15, 8));
        at = 0;
      end
      1: begin
        strm[0][3:0] = 4'(8 + $urandom_range(15, 1));
        at = 0;
      end
      2: begin
        strm[1] = strm[1] ^ {3'b0, 5'($urandom_range(31, 1))};
        at = 1;
      end
      3: begin
        // Preset dictionary with a valid check value
        strm[1][5] = 1'b1;
        strm[1][4:0] = 5'd0;
        strm[1][4:0] = 5'((31 - ({strm[0], strm[1]} % 16'd31)) % 31);
        at = 1;
      end
      4: begin
        strm[2] = strm[2] | 8'(1 << $urandom_range(7, 1));
        at = 2;
      end
      5: begin
        strm[5] = strm[5] ^ 8'($urandom_range(255, 1));
        at = 5;
      end
      6: begin
        strm[6] = strm[6] ^ 8'($urandom_range(255, 1));
        at = 6;
      end
      7: begin
        n = strm.size() - 1 - $urandom_range(3);
        strm[n] = strm[n] ^ 8'($urandom_range(255, 1));
        at = n;
      end
      8: begin
        repeat ($urandom_range(3, 1)) strm.push_back(8'($urandom_range(255)));
      end
      9: begin
        n = $urandom_range(strm.size() - 1, 1);
        while (strm.size() > n) void'(strm.pop_back());
      end
      default: ;
    endcase
    if (at >= 0 && $urandom_range(3) == 0)
      while (strm.size() > at + 1) void'(strm.pop_back());
  endfunction

  task automatic random_streams(input int target);
    while (parsed_count < target) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        strm.delete();
        repeat ($urandom_range(6, 1)) strm.push_back(8'($urandom_range(255)));
      end else begin
        make_stream($urandom_range(3, 1), 1'b0);
        if (pick > 10) corrupt_stream();
      end
      play_stream();
    end
  endtask

  // Drain: hold the sender until every expected item has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: random ready, or a long hold-off when one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  initial begin
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck = 0;
      else
        stuck++;
    end
    $display("** zlib_stored_block_decoder_unit: FAILED **");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty final block, payload of the extreme byte values,
    // then a lone bad header byte that also ends its stream
    strm = '{8'h78, 8'h01, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF,
             8'h00, 8'h00, 8'h00, 8'h01};
    play_stream();
    strm = '{8'h08, 8'h1D, 8'h01, 8'h02, 8'h00, 8'hFD, 8'hFF, 8'h00, 8'hFF,
             8'h01, 8'h01, 8'h01, 8'h00};
    play_stream();
    strm = '{8'h00};
    play_stream();
    wait_drained();

    // Random: fast sender against a mostly stalled receiver first
    random_streams(330);
    wait_drained();
    src_idle_pct = 85;
    snk_idle_pct = 17;
    random_streams(640);
    wait_drained();
    src_idle_pct = 0;
    snk_idle_pct = 0;

    // Long payload behind a held-off receiver to back the block up
    hold_seq = hold_seq + 1;
    make_stream(1, 1'b1);
    play_stream();
    random_streams(950);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** zlib_stored_block_decoder_unit: PASSED **");
    end else begin
      $display("** zlib_stored_block_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
